### src/qrs_pkg.sv
package qrs_pkg;

    // Result class codes.
    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_NOREAL = 2'd1;
    localparam logic [1:0] CLASS_SINGLE = 2'd2;
    localparam logic [1:0] CLASS_TWO    = 2'd3;

    localparam int ROOT_WIDTH = 32;

endpackage

### src/quadratic_root_solver.sv
// Pipeline from request to result: two setup stages, one stage per square
// root bit, one to finish the root, one for magnitudes, one per quotient bit
// and the output register.
// Throughput: one request per cycle; a stall freezes every stage at once.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module quadratic_root_solver #(
    parameter int COEF_WIDTH     = 16,
    parameter int ROOT_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    root_class,
    output logic signed [31:0]            root_plus,
    output logic signed [31:0]            root_minus,
    output logic                          saturated
);

    localparam int CW   = COEF_WIDTH;
    localparam int PW   = 2 * CW;          // product width
    localparam int QW   = PW + 1;          // quarter discriminant width
    localparam int SQ   = (QW + 1) / 2;    // sqrt steps
    localparam int SQW  = 2 * SQ;          // sqrt datapath width
    localparam int NMW  = CW + 2;          // numerator magnitude width
    localparam int DW   = CW + 1;          // denominator width (2|a|)
    localparam int NW   = NMW + ROOT_FRAC_BITS;
    localparam int QTW  = NW;
    localparam int RW   = qrs_pkg::ROOT_WIDTH;
    localparam int NSTG = 5 + SQ + NW;     // total register stages
    localparam logic [QTW:0] POS_MAX = (QTW+1)'(64'h7FFF_FFFF);
    localparam logic [QTW:0] NEG_MAX = (QTW+1)'(64'h8000_0000);

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic [NSTG-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // Stage 1: magnitudes and products.
    logic [PW-1:0] bb_reg, p_reg;
    logic          acneg_reg, azero_reg, aneg_reg;
    logic signed [CW:0] nb_reg;
    logic [CW-1:0] am_reg;

    logic [CW-1:0] am, bm, cm;
    assign am = coef_a[CW-1] ? CW'(-coef_a) : coef_a;
    assign bm = coef_b[CW-1] ? CW'(-coef_b) : coef_b;
    assign cm = coef_c[CW-1] ? CW'(-coef_c) : coef_c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bb_reg    <= PW'(bm) * PW'(bm);
            p_reg     <= PW'(am) * PW'(cm);
            acneg_reg <= (coef_a[CW-1] != coef_c[CW-1]) && (coef_a != '0) && (coef_c != '0);
            azero_reg <= (coef_a == '0);
            aneg_reg  <= coef_a[CW-1];
            nb_reg    <= -((CW+1)'(coef_b));
            am_reg    <= am;
        end
    end

    // Stage 2: quarter discriminant and class.
    logic [QW-1:0] q_reg;
    logic [1:0]    m_reg, cls_reg;
    logic signed [CW:0] nb2_reg;
    logic [CW-1:0] am2_reg;
    logic          aneg2_reg;

    logic [QW-1:0] qsum, qdif;
    assign qsum = QW'(bb_reg >> 2) + QW'(p_reg);
    assign qdif = QW'(bb_reg >> 2) - QW'(p_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg     <= bb_reg[1:0];
            nb2_reg   <= nb_reg;
            am2_reg   <= am_reg;
            aneg2_reg <= aneg_reg;
            q_reg     <= acneg_reg ? qsum : qdif;
            if (azero_reg)
                cls_reg <= qrs_pkg::CLASS_NONE;
            else if (!acneg_reg && ((bb_reg >> 2) < p_reg))
                cls_reg <= qrs_pkg::CLASS_NOREAL;
            else if ((acneg_reg ? qsum : qdif) == '0 && bb_reg[1:0] == 2'd0)
                cls_reg <= qrs_pkg::CLASS_SINGLE;
            else
                cls_reg <= qrs_pkg::CLASS_TWO;
        end
    end

    // Square root pipeline, one bit per stage, side data travels along.
    logic [SQW-1:0] rem_p [SQ+1];
    logic [SQW-1:0] res_p [SQ+1];
    logic [1:0]     m_p   [SQ+1];
    logic [1:0]     cl_p  [SQ+1];
    logic signed [CW:0] nb_p [SQ+1];
    logic [CW-1:0]  am_p  [SQ+1];
    logic           an_p  [SQ+1];

    assign rem_p[0] = SQW'(q_reg);
    assign res_p[0] = '0;
    assign m_p[0]   = m_reg;
    assign cl_p[0]  = cls_reg;
    assign nb_p[0]  = nb2_reg;
    assign am_p[0]  = am2_reg;
    assign an_p[0]  = aneg2_reg;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        logic [SQW-1:0] rem_c, res_c;
        logic [SQW-1:0] rem_r, res_r;
        logic [1:0]     m_r, cl_r;
        logic signed [CW:0] nb_r;
        logic [CW-1:0]  am_r;
        logic           an_r;

        qrs_sqrt_stage #(.W(SQW), .POS(SQ-1-i)) u_step (
            .rem_in (rem_p[i]),
            .res_in (res_p[i]),
            .rem_out(rem_c),
            .res_out(res_c)
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_r <= rem_c;
                res_r <= res_c;
                m_r   <= m_p[i];
                cl_r  <= cl_p[i];
                nb_r  <= nb_p[i];
                am_r  <= am_p[i];
                an_r  <= an_p[i];
            end
        end

        assign rem_p[i+1] = rem_r;
        assign res_p[i+1] = res_r;
        assign m_p[i+1]   = m_r;
        assign cl_p[i+1]  = cl_r;
        assign nb_p[i+1]  = nb_r;
        assign am_p[i+1]  = am_r;
        assign an_p[i+1]  = an_r;
    end

    // Stage: refine to floor(sqrt(4q+m)) and form the two signed numerators.
    // The remainder q - r*r decides the low bit: r*r + r < q exactly when r is
    // below the remainder, and equality means the remainder equals r.
    logic [SQ-1:0]  r;
    logic [SQ:0]    s;
    assign r = SQ'(res_p[SQ]);
    assign s = ((rem_p[SQ] > SQW'(r)) || (m_p[SQ] != 2'd0 && rem_p[SQ] == SQW'(r)))
               ? {r, 1'b1} : {r, 1'b0};

    logic signed [NMW:0] np_reg, nm_reg;
    logic [1:0]     cl3_reg;
    logic [CW-1:0]  am3_reg;
    logic           an3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl3_reg <= cl_p[SQ];
            am3_reg <= am_p[SQ];
            an3_reg <= an_p[SQ];
            if (cl_p[SQ] == qrs_pkg::CLASS_SINGLE)
            begin
                np_reg <= (NMW+1)'(nb_p[SQ]);
                nm_reg <= (NMW+1)'(nb_p[SQ]);
            end
            else
            begin
                np_reg <= (NMW+1)'(nb_p[SQ]) + (NMW+1)'(s);
                nm_reg <= (NMW+1)'(nb_p[SQ]) - (NMW+1)'(s);
            end
        end
    end

    // Stage: magnitudes and result signs ahead of the dividers.
    logic [NW-1:0] dnp_reg, dnm_reg;
    logic [DW-1:0] den_reg;
    logic          sp_reg, sm_reg;
    logic [1:0]    cl4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dnp_reg <= {NMW'(np_reg[NMW] ? -np_reg : np_reg), ROOT_FRAC_BITS'(0)};
            dnm_reg <= {NMW'(nm_reg[NMW] ? -nm_reg : nm_reg), ROOT_FRAC_BITS'(0)};
            den_reg <= {am3_reg, 1'b0};
            sp_reg  <= np_reg[NMW] != an3_reg;
            sm_reg  <= nm_reg[NMW] != an3_reg;
            cl4_reg <= cl3_reg;
        end
    end

    // Two divider pipelines, one quotient bit per stage.
    logic [DW:0]   rp_p [NW+1], rm_p [NW+1];
    logic [NW-1:0] xp_p [NW+1], xm_p [NW+1];
    logic [QTW-1:0] qp_p [NW+1], qm_p [NW+1];
    logic [DW-1:0] d_p  [NW+1];
    logic          sp_p [NW+1], sm_p [NW+1];
    logic [1:0]    c_p  [NW+1];

    assign rp_p[0] = '0;
    assign rm_p[0] = '0;
    assign xp_p[0] = dnp_reg;
    assign xm_p[0] = dnm_reg;
    assign qp_p[0] = '0;
    assign qm_p[0] = '0;
    assign d_p[0]  = den_reg;
    assign sp_p[0] = sp_reg;
    assign sm_p[0] = sm_reg;
    assign c_p[0]  = cl4_reg;

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        logic [DW:0]   rpc, rmc, rp_r, rm_r;
        logic [NW-1:0] xpc, xmc, xp_r, xm_r;
        logic          bp, bmq;
        logic [QTW-1:0] qp_r, qm_r;
        logic [DW-1:0] d_r;
        logic          sp_r, sm_r;
        logic [1:0]    c_r;

        qrs_div_stage #(.NW(NW), .DW(DW)) u_dp (
            .rem_in(rp_p[j]), .num_in(xp_p[j]), .den(d_p[j]),
            .rem_out(rpc), .num_out(xpc), .q_bit(bp)
        );
        qrs_div_stage #(.NW(NW), .DW(DW)) u_dm (
            .rem_in(rm_p[j]), .num_in(xm_p[j]), .den(d_p[j]),
            .rem_out(rmc), .num_out(xmc), .q_bit(bmq)
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rp_r <= rpc;
                rm_r <= rmc;
                xp_r <= xpc;
                xm_r <= xmc;
                qp_r <= {qp_p[j][QTW-2:0], bp};
                qm_r <= {qm_p[j][QTW-2:0], bmq};
                d_r  <= d_p[j];
                sp_r <= sp_p[j];
                sm_r <= sm_p[j];
                c_r  <= c_p[j];
            end
        end

        assign rp_p[j+1] = rp_r;
        assign rm_p[j+1] = rm_r;
        assign xp_p[j+1] = xp_r;
        assign xm_p[j+1] = xm_r;
        assign qp_p[j+1] = qp_r;
        assign qm_p[j+1] = qm_r;
        assign d_p[j+1]  = d_r;
        assign sp_p[j+1] = sp_r;
        assign sm_p[j+1] = sm_r;
        assign c_p[j+1]  = c_r;
    end

    // Final stage: sign, clip and gate by class.
    function automatic logic [RW:0] clip(input logic [QTW-1:0] q, input logic neg);
        logic [QTW:0] qe;
        logic [RW:0]  o;
        qe = {1'b0, q};
        if (neg)
        begin
            if (qe > NEG_MAX)
                o = {1'b1, 32'h8000_0000};
            else
                o = {1'b0, RW'(-qe)};
        end
        else
        begin
            if (qe > POS_MAX)
                o = {1'b1, 32'h7FFF_FFFF};
            else
                o = {1'b0, RW'(qe)};
        end
        return o;
    endfunction

    logic [RW:0] cp, cm2;
    logic        roots;
    assign cp    = clip(qp_p[NW], sp_p[NW]);
    assign cm2   = clip(qm_p[NW], sm_p[NW]);
    assign roots = (c_p[NW] == qrs_pkg::CLASS_SINGLE) || (c_p[NW] == qrs_pkg::CLASS_TWO);

    logic [1:0]  cls_o_reg;
    logic [RW-1:0] rp_o_reg, rm_o_reg;
    logic        sat_o_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_o_reg <= c_p[NW];
            rp_o_reg  <= roots ? cp[RW-1:0] : '0;
            rm_o_reg  <= roots ? cm2[RW-1:0] : '0;
            sat_o_reg <= roots && (cp[RW] || cm2[RW]);
        end
    end

    assign out_valid  = vld_reg[NSTG-1];
    assign root_class = cls_o_reg;
    assign root_plus  = rp_o_reg;
    assign root_minus = rm_o_reg;
    assign saturated  = sat_o_reg;

endmodule

### src/qrs_sqrt_stage.sv
// One combinational step of a restoring integer square root.
// Each step settles one result bit, two bits of the radicand at a time.
module qrs_sqrt_stage #(
    parameter int W   = 32,
    parameter int POS = 0
) (
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] res_in,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] res_out
);

    logic [W-1:0] bit_w;
    logic [W-1:0] trial;

    always_comb
    begin
        bit_w = '0;
        bit_w[2*POS] = 1'b1;
        trial = res_in + bit_w;
        if (rem_in >= trial)
        begin
            rem_out = rem_in - trial;
            res_out = (res_in >> 1) + bit_w;
        end
        else
        begin
            rem_out = rem_in;
            res_out = res_in >> 1;
        end
    end

endmodule

### src/qrs_div_stage.sv
// One step of a restoring divider: settles one quotient bit.
module qrs_div_stage #(
    parameter int NW = 48,
    parameter int DW = 20
) (
    input  logic [DW:0]   rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den,
    output logic [DW:0]   rem_out,
    output logic [NW-1:0] num_out,
    output logic          q_bit
);

    logic [DW+1:0] shifted;

    always_comb
    begin
        shifted = {rem_in, num_in[NW-1]};
        num_out = {num_in[NW-2:0], 1'b0};
        if (shifted >= {2'b00, den})
        begin
            q_bit   = 1'b1;
            rem_out = (DW+1)'(shifted - {2'b00, den});
        end
        else
        begin
            q_bit   = 1'b0;
            rem_out = shifted[DW:0];
        end
    end

endmodule

### sim/tb_quadratic_root_solver.sv
`timescale 1ns / 1ps

// Expected solver results, oldest first.
class root_scoreboard;
    typedef struct packed {
        logic [1:0]         cls;
        logic signed [31:0] plus;
        logic signed [31:0] minus;
        logic               sat;
    } root_result_t;

    root_result_t pending_roots[$];
    int unsigned  error_count;
    int unsigned  checked_count;
    int unsigned  class_seen[4];
    int unsigned  sat_seen;

    // Signed magnitude ratio (num << 16) / den, truncated toward zero and clipped.
    static function logic signed [31:0] scaled_root(longint num, longint den,
                                                    inout logic sat);
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned q;
        logic neg;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q = (nm << 16) / dm;
        if (neg)
        begin
            if (q > 64'd2147483648)
            begin
                q = 64'd2147483648;
                sat = 1'b1;
            end
            return 32'(64'd0 - q);
        end
        if (q > 64'd2147483647)
        begin
            q = 64'd2147483647;
            sat = 1'b1;
        end
        return 32'(q);
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Note an accepted request and predict its roots.
    function void note_request(logic signed [15:0] a, logic signed [15:0] b,
                               logic signed [15:0] c);
        root_result_t r;
        longint disc;
        longint unsigned s;
        logic sat;
        r = '0;
        sat = 1'b0;
        disc = longint'(b) * b - 4 * longint'(a) * c;
        if (a == 0)
            r.cls = qrs_pkg::CLASS_NONE;
        else if (disc < 0)
            r.cls = qrs_pkg::CLASS_NOREAL;
        else if (disc == 0)
        begin
            r.cls = qrs_pkg::CLASS_SINGLE;
            r.plus = scaled_root(-longint'(b), 2 * longint'(a), sat);
            r.minus = r.plus;
        end
        else
        begin
            r.cls = qrs_pkg::CLASS_TWO;
            s = floor_sqrt(disc);
            r.plus = scaled_root(-longint'(b) + longint'(s), 2 * longint'(a), sat);
            r.minus = scaled_root(-longint'(b) - longint'(s), 2 * longint'(a), sat);
        end
        r.sat = sat;
        pending_roots.push_back(r);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [1:0] cls, logic signed [31:0] plus,
                               logic signed [31:0] minus, logic sat);
        root_result_t e;
        if (pending_roots.size() == 0)
        begin
            $error("result with no request pending");
            error_count++;
            return;
        end
        e = pending_roots.pop_front();
        checked_count++;
        class_seen[e.cls]++;
        if (e.sat)
            sat_seen++;
        if (cls !== e.cls)
        begin
            $error("root_class expected %0d actual %0d", e.cls, cls);
            error_count++;
        end
        if (plus !== e.plus)
        begin
            $error("root_plus expected %0d actual %0d", e.plus, plus);
            error_count++;
        end
        if (minus !== e.minus)
        begin
            $error("root_minus expected %0d actual %0d", e.minus, minus);
            error_count++;
        end
        if (sat !== e.sat)
        begin
            $error("saturated expected %0d actual %0d", e.sat, sat);
            error_count++;
        end
    endfunction
endclass

module tb_quadratic_root_solver;

    localparam int RANDOM_REQUESTS = 2000;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic out_valid;
    logic out_ready;
    logic [1:0] root_class;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic saturated;

    root_scoreboard roots;
    longint cycle_count = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done = 0;

    quadratic_root_solver dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .coef_a(coef_a),
        .coef_b(coef_b),
        .coef_c(coef_c),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root_class(root_class),
        .root_plus(root_plus),
        .root_minus(root_minus),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
                                logic signed [15:0] c);
        in_valid <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        roots.note_request(a, b, c);
    endtask

    task automatic send_with_gap(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c, bit allow_gap);
        int gap;
        send_request(a, b, c);
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random coefficients: full range, small values, a forced perfect square, unit a with small c, or zero a or c.
    task automatic send_random(bit allow_gap);
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        int r1;
        int r2;
        case ($urandom_range(0, 4))
            0:
            begin
                a = 16'($urandom);
                b = 16'($urandom);
                c = 16'($urandom);
            end
            1:
            begin
                a = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                b = $signed(16'($urandom_range(0, 512))) - 16'sd256;
                c = $signed(16'($urandom_range(0, 512))) - 16'sd256;
            end
            2:
            begin
                // Integer roots r1, r2: a(x-r1)(x-r2).
                a = $signed(16'($urandom_range(1, 8))) * (($urandom & 1) ? 16'sd1 : -16'sd1);
                r1 = $signed($urandom_range(0, 60)) - 30;
                r2 = ($urandom & 1) ? r1 : $signed($urandom_range(0, 60)) - 30;
                b = 16'(-a * (r1 + r2));
                c = 16'(a * r1 * r2);
            end
            3:
            begin
                a = ($urandom & 1) ? 16'sd1 : -16'sd1;
                b = 16'($urandom);
                c = $signed(16'($urandom_range(0, 8))) - 16'sd4;
            end
            default:
            begin
                a = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
                b = 16'($urandom);
                c = ($urandom & 1) ? 16'sd0 : 16'($urandom);
            end
        endcase
        send_with_gap(a, b, c, allow_gap);
    endtask

    // Result side: random stalls and one long hold-off on request.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_requests != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                holds_done++;
            end
            stall = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            roots.check_result(root_class, root_plus, root_minus, saturated);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        roots = new();
        rst_n = 1'b0;
        in_valid <= 1'b0;
        coef_a <= '0;
        coef_b <= '0;
        coef_c <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every class, extremes, saturation, odd discriminant remainder.
        send_with_gap(16'sd0, 16'sd256, 16'sd256, 0);
        send_with_gap(16'sd0, 16'sd0, 16'sd0, 0);
        send_with_gap(16'sd256, 16'sd0, 16'sd256, 1);
        send_with_gap(16'sd256, -16'sd512, 16'sd256, 1);
        send_with_gap(16'sd256, 16'sd0, -16'sd256, 0);
        send_with_gap(16'sd1, 16'sd3, 16'sd2, 0);
        send_with_gap(16'sd1, 16'sd3, 16'sd0, 0);
        send_with_gap(-16'sd32768, -16'sd32768, -16'sd32768, 1);
        send_with_gap(16'sd32767, 16'sd32767, 16'sd32767, 0);
        send_with_gap(-16'sd32768, 16'sd32767, 16'sd32767, 0);
        send_with_gap(16'sd32767, -16'sd32768, -16'sd32768, 0);
        send_with_gap(16'sd1, -16'sd32768, 16'sd0, 0);
        send_with_gap(16'sd1, 16'sd32767, -16'sd1, 0);
        send_with_gap(-16'sd1, 16'sd32767, 16'sd1, 1);
        send_with_gap(16'sd1, -16'sd32768, -16'sd32768, 0);
        send_with_gap(-16'sd1, 16'sd0, 16'sd32767, 0);
        send_with_gap(16'sd1, 16'sd2, 16'sd1, 0);
        send_with_gap(-16'sd1, 16'sd2, -16'sd1, 0);
        send_with_gap(16'sd1, 16'sd1, 16'sd0, 0);
        send_with_gap(16'sd2, 16'sd5, 16'sd3, 0);
        send_with_gap(16'sd1, 16'sd0, 16'sd32767, 0);
        send_with_gap(16'sd1, -16'sd1, -16'sd32768, 0);

        // Pause until every directed result has come back.
        in_valid <= 1'b0;
        while (roots.pending_roots.size() != 0)
            @(posedge clk);

        // Hold off the result side while requests keep coming.
        hold_requests++;
        repeat (120) send_random(0);

        for (int i = 0; i < RANDOM_REQUESTS - 120; i++)
            send_random((i % 400) < 300);
        in_valid <= 1'b0;

        while (roots.pending_roots.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Checked %0d results: %0d not quadratic, %0d no real, %0d single, %0d two",
                 roots.checked_count, roots.class_seen[0], roots.class_seen[1],
                 roots.class_seen[2], roots.class_seen[3]);
        $display("%0d results were clipped to the root range", roots.sat_seen);
        if (roots.error_count == 0 && roots.pending_roots.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/qrs_pkg.sv
src/qrs_sqrt_stage.sv
src/qrs_div_stage.sv
src/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
